// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion forms used by the checker file lshd_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle forces a consequence in the next.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/lshd_pkg.sv =====
// ----------------------------------------------------------------------------
// lshd_pkg
// Shared types, widths, register codes and helpers of the low-speed hold
// detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lshd_pkg;

    localparam int VEL_W      = 16;
    localparam int SPEED_W    = 15;
    localparam int CNT_W      = 16;
    localparam int SQ_W       = 32;
    localparam int THR_W      = 2 * SPEED_W;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 4;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_THR     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_THR     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_WINS    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_WINS = 4'd3;

    localparam logic [SPEED_W-1:0] SLOW_THR_RST     = 15'd26;
    localparam logic [SPEED_W-1:0] FAST_THR_RST     = 15'd51;
    localparam logic [CNT_W-1:0]   HOLD_WINS_RST    = 16'd3;
    localparam logic [CNT_W-1:0]   RELEASE_WINS_RST = 16'd3;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic [SPEED_W-1:0] slow_thr;
        logic [SPEED_W-1:0] fast_thr;
    } speed_cfg_t;

    typedef struct packed {
        logic [CNT_W-1:0] hold_wins;
        logic [CNT_W-1:0] release_wins;
    } win_cfg_t;

    typedef struct packed {
        logic slow;
        logic fast;
        logic last;
    } sample_class_t;

    function automatic logic [VEL_W-1:0] vel_mag(input logic signed [VEL_W-1:0] v);
        logic [VEL_W-1:0] raw;
        raw = v;
        return raw[VEL_W-1] ? (~raw + 1'b1) : raw;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? CNT_MAX : c + 1'b1;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/low_speed_hold_detector_core.sv =====
// ----------------------------------------------------------------------------
// low_speed_hold_detector_core
// Zero-velocity detector with hysteresis over windows of 3-axis samples.
// ----------------------------------------------------------------------------
// Takes one Q7.8 velocity sample per cycle while in_stall is low. A window
// result (hold_mode, entry_candidate) is registered when the window_last
// sample leaves the queue, and only window-end samples produce a beat.
// Samples pass a two-stage square-and-sum front, then a QUEUE_DEPTH-entry
// queue into the hysteresis back end; in_stall rises when QUEUE_DEPTH
// samples are in flight, so with the default depth of 4 full rate holds
// while out_stall stays low. Registers: 0 slow speed, 1 fast speed,
// 2 slow windows to enter hold, 3 fast windows to leave hold; other
// indexes are ignored. Write them only while no sample is in flight.
`timescale 1ns / 1ps
`default_nettype none

module low_speed_hold_detector_core #(
    parameter int QUEUE_DEPTH = lshd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                                     clk,
    input  wire                                     rst_n,
    input  wire                                     cfg_we,
    input  wire [lshd_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  wire [lshd_pkg::CFG_DATA_W-1:0]          cfg_data,
    input  wire                                     in_valid,
    output logic                                    in_stall,
    input  wire logic signed [lshd_pkg::VEL_W-1:0]  vel_x,
    input  wire logic signed [lshd_pkg::VEL_W-1:0]  vel_y,
    input  wire logic signed [lshd_pkg::VEL_W-1:0]  vel_z,
    input  wire                                     window_last,
    output logic                                    out_valid,
    input  wire                                     out_stall,
    output logic                                    hold_mode,
    output logic                                    entry_candidate
);

    lshd_pkg::speed_cfg_t    speed_cfg_reg;
    lshd_pkg::win_cfg_t      win_cfg_reg;
    lshd_pkg::sample_class_t push_data, rd_data;
    logic                    push_valid, rd_valid, pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_cfg_reg.slow_thr   <= lshd_pkg::SLOW_THR_RST;
            speed_cfg_reg.fast_thr   <= lshd_pkg::FAST_THR_RST;
            win_cfg_reg.hold_wins    <= lshd_pkg::HOLD_WINS_RST;
            win_cfg_reg.release_wins <= lshd_pkg::RELEASE_WINS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lshd_pkg::CFG_SLOW_THR:
                    speed_cfg_reg.slow_thr <= cfg_data[lshd_pkg::SPEED_W-1:0];
                lshd_pkg::CFG_FAST_THR:
                    speed_cfg_reg.fast_thr <= cfg_data[lshd_pkg::SPEED_W-1:0];
                lshd_pkg::CFG_HOLD_WINS:
                    win_cfg_reg.hold_wins <= cfg_data[lshd_pkg::CNT_W-1:0];
                lshd_pkg::CFG_RELEASE_WINS:
                    win_cfg_reg.release_wins <= cfg_data[lshd_pkg::CNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    lshd_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .vel_x       (vel_x),
        .vel_y       (vel_y),
        .vel_z       (vel_z),
        .window_last (window_last),
        .speed_cfg   (speed_cfg_reg),
        .pop         (pop),
        .push_valid  (push_valid),
        .push_data   (push_data)
    );

    lshd_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (push_valid),
        .wr_data  (push_data),
        .rd_en    (pop),
        .rd_valid (rd_valid),
        .rd_data  (rd_data)
    );

    lshd_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .rd_valid        (rd_valid),
        .rd_data         (rd_data),
        .pop             (pop),
        .win_cfg         (win_cfg_reg),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .hold_mode       (hold_mode),
        .entry_candidate (entry_candidate)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/lshd_front.sv =====
// ----------------------------------------------------------------------------
// lshd_front
// Accepts samples, squares the components, sums them and classifies each
// sample as slow and/or fast. Holds the in-flight count that gates input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lshd_front #(
    parameter int QUEUE_DEPTH = lshd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 in_valid,
    output logic                                in_stall,
    input  wire logic signed [lshd_pkg::VEL_W-1:0] vel_x,
    input  wire logic signed [lshd_pkg::VEL_W-1:0] vel_y,
    input  wire logic signed [lshd_pkg::VEL_W-1:0] vel_z,
    input  wire                                 window_last,
    input  wire lshd_pkg::speed_cfg_t           speed_cfg,
    input  wire                                 pop,
    output logic                                push_valid,
    output lshd_pkg::sample_class_t             push_data
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [CW-1:0] used_reg, used_next;
    logic          accept;

    logic                         a_valid_reg, a_last_reg;
    logic [lshd_pkg::SQ_W-1:0]    sq_x_reg, sq_y_reg, sq_z_reg;
    logic [lshd_pkg::SQ_W-1:0]    sq_x_next, sq_y_next, sq_z_next;
    logic [lshd_pkg::VEL_W-1:0]   mag_x, mag_y, mag_z;

    logic                         b_valid_reg, b_last_reg;
    logic [lshd_pkg::SQ_W-1:0]    sxy_reg, sz_reg;
    logic [lshd_pkg::SQ_W-1:0]    total;

    logic [lshd_pkg::THR_W-1:0]   e2_reg, x2_reg;

    assign in_stall = (used_reg == CW'(QUEUE_DEPTH));
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        used_next = used_reg;
        case ({accept, pop})
            2'b10:   used_next = used_reg + 1'b1;
            2'b01:   used_next = used_reg - 1'b1;
            default: used_next = used_reg;
        endcase
    end

    assign mag_x     = lshd_pkg::vel_mag(vel_x);
    assign mag_y     = lshd_pkg::vel_mag(vel_y);
    assign mag_z     = lshd_pkg::vel_mag(vel_z);
    assign sq_x_next = {16'd0, mag_x} * {16'd0, mag_x};
    assign sq_y_next = {16'd0, mag_y} * {16'd0, mag_y};
    assign sq_z_next = {16'd0, mag_z} * {16'd0, mag_z};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg    <= '0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            used_reg    <= used_next;
            a_valid_reg <= accept;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        e2_reg <= {15'd0, speed_cfg.slow_thr} * {15'd0, speed_cfg.slow_thr};
        x2_reg <= {15'd0, speed_cfg.fast_thr} * {15'd0, speed_cfg.fast_thr};
        if (accept)
        begin
            sq_x_reg   <= sq_x_next;
            sq_y_reg   <= sq_y_next;
            sq_z_reg   <= sq_z_next;
            a_last_reg <= window_last;
        end
        if (a_valid_reg)
        begin
            sxy_reg    <= sq_x_reg + sq_y_reg;
            sz_reg     <= sq_z_reg;
            b_last_reg <= a_last_reg;
        end
    end

    assign total          = sxy_reg + sz_reg;
    assign push_valid     = b_valid_reg;
    assign push_data.slow = (total <= {2'b00, e2_reg});
    assign push_data.fast = (total >= {2'b00, x2_reg});
    assign push_data.last = b_last_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/lshd_queue.sv =====
// ----------------------------------------------------------------------------
// lshd_queue
// Small FIFO of classified samples between the front and back parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lshd_queue #(
    parameter int QUEUE_DEPTH = lshd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          wr_en,
    input  wire lshd_pkg::sample_class_t wr_data,
    input  wire                          rd_en,
    output logic                         rd_valid,
    output lshd_pkg::sample_class_t      rd_data
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    lshd_pkg::sample_class_t mem_reg [QUEUE_DEPTH];
    logic [AW-1:0]           wr_ptr_reg, rd_ptr_reg;
    logic [AW-1:0]           wr_ptr_next, rd_ptr_next;
    logic [CW-1:0]           count_reg, count_next;

    assign wr_ptr_next = (wr_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_comb
    begin
        case ({wr_en, rd_en})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];

endmodule

`default_nettype wire

// ===== hw/rtl/lshd_back.sv =====
// ----------------------------------------------------------------------------
// lshd_back
// Folds classified samples into the window flags, runs the hold/normal
// hysteresis counters at each window end and holds the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lshd_back (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          rd_valid,
    input  wire lshd_pkg::sample_class_t rd_data,
    output logic                         pop,
    input  wire lshd_pkg::win_cfg_t      win_cfg,
    output logic                         out_valid,
    input  wire                          out_stall,
    output logic                         hold_mode,
    output logic                         entry_candidate
);

    logic                       mode_hold_reg, mode_hold_next;
    logic [lshd_pkg::CNT_W-1:0] enter_run_reg, enter_run_next;
    logic [lshd_pkg::CNT_W-1:0] exit_run_reg, exit_run_next;
    logic                       win_all_slow_reg, win_all_slow_next;
    logic                       win_any_fast_reg, win_any_fast_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       hold_mode_reg, hold_mode_next;
    logic                       cand_reg, cand_next;

    logic                       all_slow, any_fast;
    logic [lshd_pkg::CNT_W-1:0] enter_cnt, exit_cnt;

    assign pop      = rd_valid && (!rd_data.last || !out_valid_reg || !out_stall);
    assign all_slow = win_all_slow_reg && rd_data.slow;
    assign any_fast = win_any_fast_reg || rd_data.fast;
    assign enter_cnt = all_slow ? lshd_pkg::sat_inc(enter_run_reg) : '0;
    assign exit_cnt  = any_fast ? lshd_pkg::sat_inc(exit_run_reg) : '0;

    always_comb
    begin
        mode_hold_next    = mode_hold_reg;
        enter_run_next    = enter_run_reg;
        exit_run_next     = exit_run_reg;
        win_all_slow_next = win_all_slow_reg;
        win_any_fast_next = win_any_fast_reg;
        out_valid_next    = out_valid_reg && out_stall;
        hold_mode_next    = hold_mode_reg;
        cand_next         = cand_reg;

        if (pop && !rd_data.last)
        begin
            win_all_slow_next = all_slow;
            win_any_fast_next = any_fast;
        end
        else if (pop)
        begin
            win_all_slow_next = 1'b1;
            win_any_fast_next = 1'b0;
            out_valid_next    = 1'b1;
            cand_next         = all_slow;
            if (!mode_hold_reg)
            begin
                if (enter_cnt >= win_cfg.hold_wins)
                begin
                    mode_hold_next = 1'b1;
                    enter_run_next = '0;
                end
                else
                begin
                    enter_run_next = enter_cnt;
                end
            end
            else
            begin
                if (exit_cnt >= win_cfg.release_wins)
                begin
                    mode_hold_next = 1'b0;
                    exit_run_next  = '0;
                end
                else
                begin
                    exit_run_next = exit_cnt;
                end
            end
            hold_mode_next = mode_hold_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_hold_reg    <= 1'b0;
            enter_run_reg    <= '0;
            exit_run_reg     <= '0;
            win_all_slow_reg <= 1'b1;
            win_any_fast_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            mode_hold_reg    <= mode_hold_next;
            enter_run_reg    <= enter_run_next;
            exit_run_reg     <= exit_run_next;
            win_all_slow_reg <= win_all_slow_next;
            win_any_fast_reg <= win_any_fast_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_mode_reg <= hold_mode_next;
        cand_reg      <= cand_next;
    end

    assign out_valid       = out_valid_reg;
    assign hold_mode       = hold_mode_reg;
    assign entry_candidate = cand_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/lshd_checker.sv =====
// ----------------------------------------------------------------------------
// lshd_checker
// Port-level checks of the detector: result beats track window ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lshd_checker #(
    parameter int QUEUE_DEPTH = lshd_pkg::QUEUE_DEPTH_DEF
) (
    input wire clk,
    input wire rst_n,
    input wire in_valid,
    input wire in_stall,
    input wire window_last,
    input wire out_valid,
    input wire out_stall,
    input wire hold_mode,
    input wire entry_candidate
);

    localparam int PW = $clog2(QUEUE_DEPTH + 2) + 1;

    logic [PW-1:0] pending_reg, pending_next;
    logic          in_beat, out_beat;

    assign in_beat  = in_valid && !in_stall && window_last;
    assign out_beat = out_valid && !out_stall;

    always_comb
    begin
        case ({in_beat, out_beat})
            2'b10:   pending_next = pending_reg + 1'b1;
            2'b01:   pending_next = pending_reg - 1'b1;
            default: pending_next = pending_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `ASSERT_CLKD(a_no_orphan_beat, clk, rst_n, out_valid |-> (pending_reg != '0), "result without window end")
    `ASSERT_CLKD(a_pending_bound, clk, rst_n, pending_reg <= PW'(QUEUE_DEPTH + 1), "too many windows in flight")
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(hold_mode) && $stable(entry_candidate), "stalled result changed")

endmodule

bind low_speed_hold_detector_core lshd_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_lshd_checker (.*);

`default_nettype wire

// ===== tb/sv/low_speed_hold_detector_core_tb.sv =====
// ----------------------------------------------------------------------------
// low_speed_hold_detector_core_tb
// Self-checking bench: a directed table, then windowed random traffic under
// several threshold settings and idle mixes.
// Every accepted sample runs through an in-bench hysteresis predictor, and
// each window result is compared with the oldest pending expectation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module low_speed_hold_detector_core_tb;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int DRAIN_CYCLES = 8;
    localparam int N_DIR        = 18;
    localparam int N_PHASES     = 6;
    localparam int MAG_MAX      = 32768;

    localparam int KIND_SLOW  = 0;
    localparam int KIND_FAST  = 1;
    localparam int KIND_EDGE  = 2;
    localparam int KIND_NOISE = 3;

    typedef struct packed {
        logic signed [lshd_pkg::VEL_W-1:0] vx;
        logic signed [lshd_pkg::VEL_W-1:0] vy;
        logic signed [lshd_pkg::VEL_W-1:0] vz;
        logic                              last;
        logic                              typed;
        logic                              hold;
        logic                              cand;
    } dir_row_t;

    typedef struct packed {
        logic hold;
        logic cand;
    } window_res_t;

    typedef struct {
        int enter_spd;
        int exit_spd;
        int enter_win;
        int exit_win;
        int snd_pct;
        int rcv_pct;
        int n_items;
        int press;
    } phase_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              cfg_we = 1'b0;
    logic [lshd_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
    logic [lshd_pkg::CFG_DATA_W-1:0]   cfg_data = '0;
    logic                              in_valid = 1'b0;
    logic                              in_stall;
    logic signed [lshd_pkg::VEL_W-1:0] vel_x = '0;
    logic signed [lshd_pkg::VEL_W-1:0] vel_y = '0;
    logic signed [lshd_pkg::VEL_W-1:0] vel_z = '0;
    logic                              window_last = 1'b0;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic                              hold_mode;
    logic                              entry_candidate;

    // predictor state
    logic [lshd_pkg::SPEED_W-1:0] p_slow_thr;
    logic [lshd_pkg::SPEED_W-1:0] p_fast_thr;
    logic [lshd_pkg::CNT_W-1:0]   p_enter_win;
    logic [lshd_pkg::CNT_W-1:0]   p_exit_win;
    logic [lshd_pkg::CNT_W-1:0]   slow_run;
    logic [lshd_pkg::CNT_W-1:0]   fast_run;
    logic                         p_hold;
    logic                         p_cand;
    logic                         acc_slow;
    logic                         acc_fast;

    window_res_t pending_windows[$];
    dir_row_t    dir_tab [0:N_DIR-1];
    phase_t      phases [0:N_PHASES-1];

    int errors = 0;
    int cycles = 0;
    int sender_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_req = 0;
    int hold_left = 0;

    low_speed_hold_detector_core DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .vel_x           (vel_x),
        .vel_y           (vel_y),
        .vel_z           (vel_z),
        .window_last     (window_last),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .hold_mode       (hold_mode),
        .entry_candidate (entry_candidate)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("** low_speed_hold_detector_core: FAILED **");
            $finish;
        end
    end

    // receiver: random stall, or a long hold-off when requested
    always @(posedge clk)
    begin
        if (hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        window_res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_windows.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat hold_mode=%0b entry_candidate=%0b",
                         $time, hold_mode, entry_candidate);
            end
            else
            begin
                want = pending_windows.pop_front();
                if (hold_mode !== want.hold)
                begin
                    errors++;
                    $display("%0t: hold_mode expected %0b got %0b",
                             $time, want.hold, hold_mode);
                end
                if (entry_candidate !== want.cand)
                begin
                    errors++;
                    $display("%0t: entry_candidate expected %0b got %0b",
                             $time, want.cand, entry_candidate);
                end
            end
        end
    end

    function automatic logic [31:0] sq_mag(input logic signed [lshd_pkg::VEL_W-1:0] v);
        logic [16:0] m;
        m = (v < 0) ? 17'(-int'(v)) : 17'(int'(v));
        return m * m;
    endfunction

    function automatic logic [lshd_pkg::CNT_W-1:0] run_inc(
        input logic [lshd_pkg::CNT_W-1:0] c);
        return (c == lshd_pkg::CNT_MAX) ? lshd_pkg::CNT_MAX : c + 1'b1;
    endfunction

    task automatic hold_model_reset();
        p_slow_thr  = lshd_pkg::SLOW_THR_RST;
        p_fast_thr  = lshd_pkg::FAST_THR_RST;
        p_enter_win = lshd_pkg::HOLD_WINS_RST;
        p_exit_win  = lshd_pkg::RELEASE_WINS_RST;
        slow_run    = '0;
        fast_run    = '0;
        p_hold      = 1'b0;
        p_cand      = 1'b0;
        acc_slow    = 1'b1;
        acc_fast    = 1'b0;
    endtask

    task automatic hold_model_step(input logic signed [lshd_pkg::VEL_W-1:0] vx, vy, vz,
                                   input logic last);
        logic [33:0] norm_sq;
        logic [29:0] slow_sq;
        logic [29:0] fast_sq;
        logic        now_slow;
        logic        now_fast;
        norm_sq  = sq_mag(vx) + sq_mag(vy) + sq_mag(vz);
        slow_sq  = p_slow_thr * p_slow_thr;
        fast_sq  = p_fast_thr * p_fast_thr;
        now_slow = acc_slow && (norm_sq <= slow_sq);
        now_fast = acc_fast || (norm_sq >= fast_sq);
        if (!last)
        begin
            acc_slow = now_slow;
            acc_fast = now_fast;
        end
        else
        begin
            p_cand = now_slow;
            if (!p_hold)
            begin
                slow_run = now_slow ? run_inc(slow_run) : '0;
                if (slow_run >= p_enter_win)
                begin
                    p_hold = 1'b1;
                    slow_run = '0;
                end
            end
            else
            begin
                fast_run = now_fast ? run_inc(fast_run) : '0;
                if (fast_run >= p_exit_win)
                begin
                    p_hold = 1'b0;
                    fast_run = '0;
                end
            end
            acc_slow = 1'b1;
            acc_fast = 1'b0;
            pending_windows.push_back('{hold: p_hold, cand: p_cand});
        end
    endtask

    task automatic send_sample(input logic signed [lshd_pkg::VEL_W-1:0] vx, vy, vz,
                               input logic last);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        vel_x       <= vx;
        vel_y       <= vy;
        vel_z       <= vz;
        window_last <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        hold_model_step(vx, vy, vz, last);
    endtask

    task automatic write_reg(input logic [lshd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lshd_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            lshd_pkg::CFG_SLOW_THR:     p_slow_thr  = data[lshd_pkg::SPEED_W-1:0];
            lshd_pkg::CFG_FAST_THR:     p_fast_thr  = data[lshd_pkg::SPEED_W-1:0];
            lshd_pkg::CFG_HOLD_WINS:    p_enter_win = data;
            lshd_pkg::CFG_RELEASE_WINS: p_exit_win  = data;
            default: ;
        endcase
    endtask

    // speed writes carry a random top bit, which the register must drop
    task automatic configure(input int es, xs, ew, xw);
        write_reg(lshd_pkg::CFG_SLOW_THR,
                  {1'($urandom_range(1)), lshd_pkg::SPEED_W'(es)});
        write_reg(lshd_pkg::CFG_FAST_THR,
                  {1'($urandom_range(1)), lshd_pkg::SPEED_W'(xs)});
        write_reg(lshd_pkg::CFG_HOLD_WINS, lshd_pkg::CNT_W'(ew));
        write_reg(lshd_pkg::CFG_RELEASE_WINS, lshd_pkg::CNT_W'(xw));
        write_reg(lshd_pkg::CFG_IDX_W'($urandom_range(lshd_pkg::CFG_RELEASE_WINS + 1,
                                                      2**lshd_pkg::CFG_IDX_W - 1)),
                  lshd_pkg::CFG_DATA_W'($urandom));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_windows.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [lshd_pkg::VEL_W-1:0] signed_vel(input int mag);
        if (mag >= MAG_MAX)
            return {1'b1, {(lshd_pkg::VEL_W-1){1'b0}}};
        return $urandom_range(1) ? lshd_pkg::VEL_W'(-mag) : lshd_pkg::VEL_W'(mag);
    endfunction

    task automatic gen_sample(input int kind,
                              output logic signed [lshd_pkg::VEL_W-1:0] v [3]);
        int big;
        int thr;
        int mag;
        big = $urandom_range(2);
        for (int a = 0; a < 3; a++)
        begin
            case (kind)
                KIND_SLOW:
                    v[a] = signed_vel($urandom_range(0, int'(p_slow_thr) / 2));
                KIND_FAST:
                    v[a] = (a == big) ? signed_vel($urandom_range(p_fast_thr, MAG_MAX))
                                      : signed_vel($urandom_range(0, MAG_MAX));
                KIND_EDGE:
                    v[a] = '0;
                default:
                    v[a] = lshd_pkg::VEL_W'($urandom);
            endcase
        end
        if (kind == KIND_EDGE)
        begin
            thr = $urandom_range(1) ? int'(p_slow_thr) : int'(p_fast_thr);
            mag = thr + $urandom_range(0, 4) - 2;
            v[big] = signed_vel((mag < 0) ? 0 : mag);
        end
    endtask

    // runs of windows share one kind; a few samples break the pattern
    task automatic run_traffic(input int n_items);
        int                                sent;
        int                                kind;
        int                                sk;
        int                                wlen;
        logic signed [lshd_pkg::VEL_W-1:0] v [3];
        sent = 0;
        while (sent < n_items)
        begin
            kind = $urandom_range(KIND_NOISE);
            repeat ($urandom_range(1, 6))
            begin
                wlen = ($urandom_range(9) == 0) ? $urandom_range(5, 12)
                                                : $urandom_range(1, 3);
                for (int k = 0; k < wlen; k++)
                begin
                    sk = (kind == KIND_NOISE || $urandom_range(15) == 0)
                         ? $urandom_range(KIND_NOISE) : kind;
                    gen_sample(sk, v);
                    send_sample(v[0], v[1], v[2], k == wlen - 1);
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        dir_tab = '{
            '{16'sd0,      16'sd0,      16'sd0,      1'b1, 1'b1, 1'b0, 1'b1},
            '{16'sd26,     16'sd0,      16'sd0,      1'b1, 1'b1, 1'b0, 1'b1},
            '{16'sd0,      16'sd0,      -16'sd26,    1'b0, 1'b0, 1'b0, 1'b0},
            '{16'sd0,      16'sd27,     16'sd0,      1'b1, 1'b1, 1'b0, 1'b0},
            '{16'sd1,      -16'sd1,     16'sd1,      1'b1, 1'b1, 1'b0, 1'b1},
            '{-16'sd1,     16'sd1,      -16'sd1,     1'b1, 1'b1, 1'b0, 1'b1},
            '{16'sd15,     16'sd15,     16'sd15,     1'b1, 1'b1, 1'b1, 1'b1},
            '{16'sd51,     16'sd0,      16'sd0,      1'b1, 1'b1, 1'b1, 1'b0},
            '{-16'sd32768, -16'sd32768, -16'sd32768, 1'b0, 1'b0, 1'b0, 1'b0},
            '{16'sd32767,  16'sd32767,  16'sd32767,  1'b1, 1'b1, 1'b1, 1'b0},
            '{16'sd0,      16'sd0,      16'sd0,      1'b1, 1'b1, 1'b1, 1'b1},
            '{16'sd30,     16'sd0,      16'sd0,      1'b1, 1'b1, 1'b1, 1'b0},
            '{-16'sd51,    16'sd0,      16'sd0,      1'b1, 1'b1, 1'b1, 1'b0},
            '{16'sd0,      -16'sd51,    16'sd0,      1'b1, 1'b1, 1'b1, 1'b0},
            '{16'sd0,      16'sd0,      -16'sd51,    1'b1, 1'b1, 1'b0, 1'b0},
            '{-16'sd32768, 16'sd0,      16'sd0,      1'b0, 1'b0, 1'b0, 1'b0},
            '{16'sd0,      -16'sd1,     16'sd0,      1'b1, 1'b1, 1'b0, 1'b0},
            '{16'sd21845,  -16'sd21846, -16'sd1,     1'b1, 1'b0, 1'b0, 1'b0}
        };
        phases = '{
            '{26,    51,    3, 3,  0,  0,  130, 0},
            '{0,     0,     0, 0,  80, 0,  110, 0},
            '{32767, 32767, 1, 1,  0,  80, 110, 0},
            '{300,   120,   2, 4,  22, 22, 130, 0},
            '{600,   900,   4, 2,  0,  0,  140, 1},
            '{2000,  2200,  5, 1,  80, 0,  130, 0}
        };

        hold_model_reset();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values
        for (int i = 0; i < N_DIR; i++)
        begin
            send_sample(dir_tab[i].vx, dir_tab[i].vy, dir_tab[i].vz, dir_tab[i].last);
            if (dir_tab[i].typed)
                pending_windows[pending_windows.size() - 1] =
                    '{hold: dir_tab[i].hold, cand: dir_tab[i].cand};
        end

        foreach (phases[p])
        begin
            drain();
            configure(phases[p].enter_spd, phases[p].exit_spd,
                      phases[p].enter_win, phases[p].exit_win);
            sender_idle_pct = phases[p].snd_pct;
            recv_stall_pct  = phases[p].rcv_pct;
            if (phases[p].press != 0)
                hold_req = 300;
            run_traffic(phases[p].n_items);
        end

        drain();
        if (errors == 0)
            $display("** low_speed_hold_detector_core: PASSED **");
        else
            $display("** low_speed_hold_detector_core: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/lshd_pkg.sv
hw/rtl/lshd_front.sv
hw/rtl/lshd_queue.sv
hw/rtl/lshd_back.sv
hw/rtl/low_speed_hold_detector_core.sv
hw/rtl/lshd_checker.sv
tb/sv/low_speed_hold_detector_core_tb.sv
